// ===== src/tadv_pkg.sv =====
// Package for the triple attack/decay VCA: shared constants, the exp2 table,
// the constant dividers, the rate/gain bundle type and the register index codes.
// No dependencies.
package tadv_pkg;

    localparam int NUM_W  = 44;  // divider dividend width
    localparam int DEN_W  = 18;  // divider divisor width
    localparam int QUO_W  = 25;  // divider quotient width
    localparam int ENV_W  = 24;  // envelope level, Q0.24
    localparam int RATE_W = 25;  // rate (one is 2^24) and gain (Q16)
    localparam int CH_W   = 4;

    localparam logic [RATE_W-1:0] ENV_ONE    = 25'h100_0000;
    localparam logic [ENV_W-1:0]  ENV_MAX    = 24'hFF_FFFF;
    localparam logic [RATE_W-1:0] ATTACK_END = 25'd15938355;
    localparam int                TRIG_LOW   = 204;
    localparam int                TRIG_HIGH  = 4096;

    // floor division by a constant: bias the dividend by d*K to make it
    // non-negative, multiply by ceil(2^36/d), drop 36 bits, remove K
    localparam logic [31:0] DIV20_M     = 32'd3435973837;
    localparam logic [25:0] DIV20_K     = 26'd419431;
    localparam logic [29:0] DIV20_BIAS  = 30'd8388620;
    localparam logic [31:0] DIV80_M     = 32'd858993460;
    localparam logic [25:0] DIV80_K     = 26'd104858;
    localparam logic [29:0] DIV80_BIAS  = 30'd8388640;
    localparam logic [31:0] DIV100_M    = 32'd687194768;
    localparam logic [25:0] DIV100_K    = 26'd1006633;
    localparam logic [29:0] DIV100_BIAS = 30'd100663300;

    typedef enum logic [2:0] {
        CFG_CHANNELS = 3'd0,
        CFG_PITCH    = 3'd1,
        CFG_ATTACK   = 3'd2,
        CFG_DECAY    = 3'd3,
        CFG_RATE     = 3'd4,
        CFG_OUTPUTS  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [RATE_W-1:0] attack;
        logic [RATE_W-1:0] decay;
        logic [RATE_W-1:0] gain;
    } tadv_rates_t;

    // 2^(i/16) in Q16
    function automatic logic [17:0] tadv_exp_tab(input logic [4:0] idx);
        logic [17:0] v;
        unique case (idx)
            5'd0:  v = 18'd65536;
            5'd1:  v = 18'd68438;
            5'd2:  v = 18'd71468;
            5'd3:  v = 18'd74632;
            5'd4:  v = 18'd77936;
            5'd5:  v = 18'd81386;
            5'd6:  v = 18'd84990;
            5'd7:  v = 18'd88752;
            5'd8:  v = 18'd92682;
            5'd9:  v = 18'd96785;
            5'd10: v = 18'd101070;
            5'd11: v = 18'd105545;
            5'd12: v = 18'd110218;
            5'd13: v = 18'd115098;
            5'd14: v = 18'd120194;
            5'd15: v = 18'd125515;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

    // interpolated mantissa of 2^(frac/256), Q16
    function automatic logic [17:0] tadv_exp_mant(input logic [7:0] frac);
        logic [17:0] lo;
        logic [17:0] hi;
        logic [16:0] dlt;
        logic [21:0] acc;
        lo  = tadv_exp_tab({1'b0, frac[7:4]});
        hi  = tadv_exp_tab({1'b0, frac[7:4]} + 5'd1);
        dlt = 17'(hi - lo);
        acc = 22'(dlt * frac[3:0]) + 22'd8;
        return lo + 18'(acc >> 4);
    endfunction

    // floor(n / d) for a constant d given by its bias, offset and reciprocal
    function automatic logic signed [25:0] tadv_fdiv_const(input logic signed [29:0] n,
                                                           input logic [29:0] bias,
                                                           input logic [25:0] k,
                                                           input logic [31:0] m);
        logic [29:0] u;
        logic [59:0] p;
        u = n + bias;
        p = 60'(u[27:0]) * 60'(m);
        return $signed(26'(p >> 36) - k);
    endfunction

endpackage

// ===== src/triple_attack_decay_vca.sv =====
// Top level of the triple attack/decay VCA: handshakes, configuration
// registers, divider sequencing and output register. Depends on tadv_pkg,
// tadv_div and tadv_voice.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+----------------------------------------
//  s_ (in)   | s_valid / s_ready     | pitch/gain/time cv, audio+triggers x3
//  m_ (out)  | m_valid / m_ready     | channel, pitch_out_a..c, sound_out_a..c
//  cfg       | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// One request at a time. The steps from one accepted request to the next are
// the accepting idle state, the reciprocal multiplies (time cv by 20, gain cv
// by 80, pitch sums by 100), the gain exponent, the two bit-serial rate
// dividers against the sample rate, the voice loop (a state memory
// read-modify-write per voice, plus start, finish and done), and loading the
// output.
// s_ready rises again as soon as the result sits in the output register, so
// the next request is taken while a stalled result waits for m_ready.
// Synchronous active-low reset clears the state memory via valid bits at once:
// silence, in decay, trigger high; channel counter zero.
module triple_attack_decay_vca
    import tadv_pkg::*;
#(
    parameter int MAX_CHANNELS = 16,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_pitch_cv,
    input  logic signed [SAMPLE_BITS-1:0] s_gain_cv,
    input  logic signed [SAMPLE_BITS-1:0] s_time_cv,
    input  logic signed [SAMPLE_BITS-1:0] s_audio_a,
    input  logic signed [SAMPLE_BITS-1:0] s_fourth_a,
    input  logic signed [SAMPLE_BITS-1:0] s_fifth_a,
    input  logic signed [SAMPLE_BITS-1:0] s_audio_b,
    input  logic signed [SAMPLE_BITS-1:0] s_fourth_b,
    input  logic signed [SAMPLE_BITS-1:0] s_fifth_b,
    input  logic signed [SAMPLE_BITS-1:0] s_audio_c,
    input  logic signed [SAMPLE_BITS-1:0] s_fourth_c,
    input  logic signed [SAMPLE_BITS-1:0] s_fifth_c,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [CH_W-1:0]               m_channel,
    output logic signed [SAMPLE_BITS-1:0] m_pitch_out_a,
    output logic signed [SAMPLE_BITS-1:0] m_pitch_out_b,
    output logic signed [SAMPLE_BITS-1:0] m_pitch_out_c,
    output logic signed [SAMPLE_BITS-1:0] m_sound_out_a,
    output logic signed [SAMPLE_BITS-1:0] m_sound_out_b,
    output logic signed [SAMPLE_BITS-1:0] m_sound_out_c,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [17:0]                   cfg_data
);
    localparam int SB = SAMPLE_BITS;
    localparam logic signed [35:0] SAT_HI = 36'((64'sd1 <<< (SB - 1)) - 1);
    localparam logic signed [35:0] SAT_LO = -SAT_HI - 36'sd1;

    typedef enum logic [2:0] {S_IDLE, S_QUO, S_GAIN, S_DST, S_DW, S_VST, S_VW, S_OUT} state_t;

    state_t state_reg;

    // configuration
    logic [4:0]         chans_reg;
    logic signed [14:0] pofs_reg;
    logic signed [12:0] atk_reg;
    logic signed [12:0] dcy_reg;
    logic [17:0]        fs_reg;
    logic [2:0]         conn_reg;

    // captured request
    logic signed [SB-1:0] pcv_reg;
    logic signed [SB-1:0] gcv_reg;
    logic signed [SB-1:0] tcv_reg;
    logic signed [SB-1:0] au_reg [3];
    logic signed [SB-1:0] t4_reg [3];
    logic signed [SB-1:0] t5_reg [3];
    logic [CH_W-1:0] cnt_reg;
    logic [CH_W-1:0] ch_reg;

    // intermediate results
    logic signed [25:0] cvs_reg;
    logic signed [25:0] gidx_reg;
    logic signed [25:0] pq_reg [3];
    logic [RATE_W-1:0]  ra_reg;
    logic [RATE_W-1:0]  rd_reg;
    logic [RATE_W-1:0]  gain_reg;
    logic [1:0]         satr_reg;

    // constant divisions
    logic signed [25:0] cvs_c;
    logic signed [25:0] gidx_c;
    logic signed [25:0] pq_c [3];

    // rate dividers
    logic [NUM_W-1:0] dnum [2];
    logic [QUO_W-1:0] dquo [2];
    logic [1:0]       dovf;
    logic [1:0]       ddone;
    logic [1:0]       dsat;
    logic             div_start;

    logic [CH_W-1:0]  ch_cur;
    logic [CH_W-1:0]  ch_next;
    logic [4:0]       nch;

    logic [RATE_W-1:0] gain_c;
    logic signed [31:0] pn [3];
    logic [DEN_W-1:0]  fsd;
    logic [NUM_W:0]    rna;
    logic [NUM_W:0]    rnd;

    tadv_rates_t rates;
    logic [1:0]  vsel;
    logic signed [SB-1:0] snd_a;
    logic signed [SB-1:0] snd_sum;
    logic signed [SB-1:0] snd_c;
    logic        vdone;

    function automatic logic signed [SB-1:0] sat_sb(input logic signed [35:0] v);
        if (v > SAT_HI) return SB'(SAT_HI);
        if (v < SAT_LO) return SB'(SAT_LO);
        return SB'(v);
    endfunction

    // rate dividend {saturate, 2^(24 - e/256) scaled by 2^16 shift}
    function automatic logic [NUM_W:0] rate_num(input logic signed [12:0] tm,
                                                input logic signed [25:0] cvs);
        logic signed [26:0] xr;
        logic signed [26:0] s;
        logic signed [26:0] ns;
        logic [17:0]        mant;
        xr   = -(27'(tm) + 27'(cvs));
        s    = (xr >>> 8) + 27'sd8;
        ns   = -s;
        mant = tadv_exp_mant(xr[7:0]);
        if (s > 27'sd26)
            return {1'b1, {NUM_W{1'b0}}};
        if (s >= 0)
            return {1'b0, NUM_W'(mant) << s[4:0]};
        if (s < -27'sd17)
            return '0;
        return {1'b0, NUM_W'(mant >> ns[4:0])};
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign div_start = (state_reg == S_DST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chans_reg <= 5'd1;
            pofs_reg  <= '0;
            atk_reg   <= -13'sd768;
            dcy_reg   <= -13'sd768;
            fs_reg    <= 18'd48000;
            conn_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CHANNELS: chans_reg <= cfg_data[4:0];
                CFG_PITCH:    pofs_reg  <= cfg_data[14:0];
                CFG_ATTACK:   atk_reg   <= cfg_data[12:0];
                CFG_DECAY:    dcy_reg   <= cfg_data[12:0];
                CFG_RATE:     fs_reg    <= cfg_data;
                CFG_OUTPUTS:  conn_reg  <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // channel bookkeeping: clamp count, wrap counter
    always_comb begin
        nch = chans_reg;
        if (nch == 5'd0)
            nch = 5'd1;
        if (int'(nch) > MAX_CHANNELS)
            nch = 5'(MAX_CHANNELS);
        ch_cur  = (int'(cnt_reg) >= MAX_CHANNELS) ? '0 : cnt_reg;
        ch_next = ((5'(ch_cur) + 5'd1) >= nch) ? '0 : CH_W'(ch_cur + 1'b1);
    end

    // constant divisions by reciprocal multiply, rate dividends for the dividers
    always_comb begin
        fsd = (fs_reg == '0) ? 18'd1 : fs_reg;
        for (int i = 0; i < 3; i++) begin
            pn[i]   = 32'(t4_reg[i]) * 5 + 32'(t5_reg[i]) * 7 + 50;
            pq_c[i] = tadv_fdiv_const(30'(pn[i]), DIV100_BIAS, DIV100_K, DIV100_M);
        end
        cvs_c   = tadv_fdiv_const(30'(tcv_reg) + 30'sd10, DIV20_BIAS, DIV20_K, DIV20_M);
        gidx_c  = tadv_fdiv_const(30'(gcv_reg) + 30'sd40, DIV80_BIAS, DIV80_K, DIV80_M);
        rna     = rate_num(atk_reg, cvs_reg);
        rnd     = rate_num(dcy_reg, cvs_reg);
        dsat    = {rnd[NUM_W], rna[NUM_W]};
        dnum[0] = rna[NUM_W-1:0];
        dnum[1] = rnd[NUM_W-1:0];
    end

    // gain 2^(idx/256) in Q16, capped at ENV_ONE (2^24)
    always_comb begin
        logic signed [25:0] kk;
        logic signed [25:0] nk;
        logic [17:0]        mant;
        kk   = gidx_reg >>> 8;
        nk   = -kk;
        mant = tadv_exp_mant(gidx_reg[7:0]);
        if (kk > 26'sd7)
            gain_c = ENV_ONE;
        else if (kk >= 0)
            gain_c = RATE_W'(mant) << kk[2:0];
        else if (kk < -26'sd17)
            gain_c = '0;
        else
            gain_c = RATE_W'(mant >> nk[4:0]);
        if (gain_c > ENV_ONE)
            gain_c = ENV_ONE;
    end

    for (genvar i = 0; i < 2; i++) begin : g_div
        tadv_div u_div (
            .clk   (aclk),
            .rst_n (aresetn),
            .start (div_start),
            .num   (dnum[i]),
            .den   (fsd),
            .quo   (dquo[i]),
            .ovf   (dovf[i]),
            .done  (ddone[i])
        );
    end

    assign rates = '{attack: ra_reg, decay: rd_reg, gain: gain_reg};

    tadv_voice #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_voice (
        .clk       (aclk),
        .rst_n     (aresetn),
        .start     (state_reg == S_VST),
        .ch        (ch_reg),
        .rates     (rates),
        .connected (conn_reg),
        .audio_in  (au_reg[vsel]),
        .tsum_in   ((SB + 1)'(t4_reg[vsel]) + (SB + 1)'(t5_reg[vsel])),
        .vsel      (vsel),
        .snd_a     (snd_a),
        .snd_sum   (snd_sum),
        .snd_c     (snd_c),
        .done      (vdone)
    );

    // capture the request
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pcv_reg   <= s_pitch_cv;
            gcv_reg   <= s_gain_cv;
            tcv_reg   <= s_time_cv;
            au_reg[0] <= s_audio_a;
            au_reg[1] <= s_audio_b;
            au_reg[2] <= s_audio_c;
            t4_reg[0] <= s_fourth_a;
            t4_reg[1] <= s_fourth_b;
            t4_reg[2] <= s_fourth_c;
            t5_reg[0] <= s_fifth_a;
            t5_reg[1] <= s_fifth_b;
            t5_reg[2] <= s_fifth_c;
            ch_reg    <= ch_cur;
        end
        if (state_reg == S_QUO) begin
            cvs_reg   <= cvs_c;
            gidx_reg  <= gidx_c;
            pq_reg[0] <= pq_c[0];
            pq_reg[1] <= pq_c[1];
            pq_reg[2] <= pq_c[2];
        end
        if (state_reg == S_GAIN)
            gain_reg <= gain_c;
        if (div_start)
            satr_reg <= dsat;
        if (state_reg == S_DW && (&ddone)) begin
            ra_reg <= (satr_reg[0] || dovf[0] || dquo[0] > ENV_ONE) ? ENV_ONE : dquo[0];
            rd_reg <= (satr_reg[1] || dovf[1] || dquo[1] > ENV_ONE) ? ENV_ONE : dquo[1];
        end
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            m_valid   <= 1'b0;
        end else begin
            if (state_reg == S_OUT && (!m_valid || m_ready))
                m_valid <= 1'b1;
            else if (m_valid && m_ready)
                m_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        cnt_reg   <= ch_next;
                        state_reg <= S_QUO;
                    end
                end
                S_QUO:  state_reg <= S_GAIN;
                S_GAIN: state_reg <= S_DST;
                S_DST:  state_reg <= S_DW;
                S_DW:   if (&ddone) state_reg <= S_VST;
                S_VST:  state_reg <= S_VW;
                S_VW:   if (vdone) state_reg <= S_OUT;
                S_OUT: begin
                    // hold until the output register is free
                    if (!m_valid || m_ready) begin
                        m_channel     <= ch_reg;
                        m_pitch_out_a <= sat_sb(36'(pcv_reg) + 36'(pofs_reg) + 36'(pq_reg[0]));
                        m_pitch_out_b <= sat_sb(36'(pcv_reg) + 36'(pofs_reg) + 36'(pq_reg[1]));
                        m_pitch_out_c <= sat_sb(36'(pcv_reg) + 36'(pofs_reg) + 36'(pq_reg[2]));
                        m_sound_out_a <= snd_a;
                        m_sound_out_b <= snd_sum;
                        m_sound_out_c <= snd_c;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== src/tadv_div.sv =====
// Restoring divider, one quotient bit per cycle, 25-bit quotient with overflow flag.
// Depends on tadv_pkg.
module tadv_div
    import tadv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic             ovf,
    output logic             done
);
    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] dsh_reg;
    logic [QUO_W-1:0] quo_reg;
    logic             ovf_reg;
    logic [4:0]       cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic             ge;

    assign ge = rem_reg >= dsh_reg;

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= 5'(QUO_W - 1);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            rem_reg <= num;
            dsh_reg <= NUM_W'(den) << (QUO_W - 1);
            ovf_reg <= num >= (NUM_W'(den) << QUO_W);
            quo_reg <= '0;
        end else if (run_reg) begin
            if (ge)
                rem_reg <= rem_reg - dsh_reg;
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign quo  = quo_reg;
    assign ovf  = ovf_reg;
    assign done = done_reg;
endmodule

// ===== src/tadv_voice.sv =====
// Voice engine: per-voice state memory and the read-modify-write sequence for
// trigger, envelope and amplitude of the three voices. Depends on tadv_pkg.
module tadv_voice
    import tadv_pkg::*;
#(
    parameter int MAX_CHANNELS = 16,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [CH_W-1:0]               ch,
    input  tadv_rates_t                   rates,
    input  logic [2:0]                    connected,
    input  logic signed [SAMPLE_BITS-1:0] audio_in,
    input  logic signed [SAMPLE_BITS:0]   tsum_in,
    output logic [1:0]                    vsel,
    output logic signed [SAMPLE_BITS-1:0] snd_a,
    output logic signed [SAMPLE_BITS-1:0] snd_sum,
    output logic signed [SAMPLE_BITS-1:0] snd_c,
    output logic                          done
);
    localparam int SB    = SAMPLE_BITS;
    localparam int DEPTH = 3 * MAX_CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int GM_W  = SB + 9;
    localparam int SUM_W = SB + 12;
    localparam int WW    = ENV_W + 2;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (SB - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    typedef enum logic [2:0] {V_IDLE, V_RD, V_TRG, V_MUL, V_UPD, V_AMP, V_ACC, V_FIN} vstate_t;

    vstate_t state_reg;
    logic [1:0] vidx_reg;

    logic [WW-1:0] mem [DEPTH];
    logic [WW-1:0] rdata_reg;
    logic          rvalid_reg;
    logic [DEPTH-1:0] vld_reg;
    logic [AW-1:0] addr;

    logic [ENV_W-1:0]  env1_reg;
    logic              atk1_reg;
    logic              trig1_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [GM_W-1:0]   gm_reg;
    logic              neg_reg;
    logic [ENV_W-1:0]  pr_reg;
    logic [ENV_W-1:0]  xo_reg;
    logic [GM_W-1:0]   am_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SB-1:0] snda_reg;
    logic signed [SB-1:0] sndc_reg;
    logic signed [SB-1:0] sums_reg;
    logic done_reg;

    // trigger stage
    logic [WW-1:0]    word;
    logic             trig_w;
    logic             atk_w;
    logic [ENV_W-1:0] env_w;
    logic             fire;
    logic             trig_n;
    logic [ENV_W-1:0] env1;
    logic [SB-1:0]    mag;

    // update stage
    logic [ENV_W-1:0]  env2;
    logic [RATE_W-1:0] xup;
    logic [ENV_W-1:0]  env3;
    logic              atk3;
    logic [ENV_W-1:0]  xo;
    logic signed [SUM_W-1:0] snd;

    function automatic logic signed [SB-1:0] sat_sb(input logic signed [SUM_W-1:0] v);
        if (v > SAT_HI) return SB'(SAT_HI);
        if (v < SAT_LO) return SB'(SAT_LO);
        return SB'(v);
    endfunction

    assign addr = AW'(int'(vidx_reg) * MAX_CHANNELS + int'(ch));
    assign vsel = vidx_reg;

    always_comb begin
        word   = rvalid_reg ? rdata_reg : {1'b1, 1'b0, {ENV_W{1'b0}}};
        trig_w = word[WW-1];
        atk_w  = word[WW-2];
        env_w  = word[ENV_W-1:0];
        fire   = 1'b0;
        trig_n = trig_w;
        if (trig_w) begin
            if ($signed(tsum_in) <= TRIG_LOW)
                trig_n = 1'b0;
        end else if ($signed(tsum_in) >= TRIG_HIGH) begin
            trig_n = 1'b1;
            fire   = 1'b1;
        end
        env1 = env_w;
        if (fire)
            env1 = (env_w == '0) ? ENV_MAX : ENV_W'(ENV_ONE - RATE_W'(env_w));
        mag = audio_in[SB-1] ? SB'(-audio_in) : SB'(audio_in);
    end

    always_comb begin
        env2 = env1_reg - pr_reg;
        xup  = ENV_ONE - RATE_W'(env2);
        env3 = env2;
        atk3 = 1'b0;
        xo   = env2;
        if (atk1_reg) begin
            atk3 = 1'b1;
            xo   = (xup > RATE_W'(ENV_MAX)) ? ENV_MAX : ENV_W'(xup);
            if (xup > ATTACK_END) begin
                atk3 = 1'b0;
                env3 = xo;
            end
        end
        snd = neg_reg ? -SUM_W'(am_reg) : SUM_W'(am_reg);
    end

    // state memory
    always_ff @(posedge clk) begin
        if (state_reg == V_UPD)
            mem[addr] <= {trig1_reg, atk3, env3};
        if (state_reg == V_RD)
            rdata_reg <= mem[addr];
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            vld_reg    <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (state_reg == V_UPD)
                vld_reg[addr] <= 1'b1;
            if (state_reg == V_RD)
                rvalid_reg <= vld_reg[addr];
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg <= V_IDLE;
            vidx_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                V_IDLE: begin
                    if (start) begin
                        vidx_reg  <= '0;
                        sum_reg   <= '0;
                        state_reg <= V_RD;
                    end
                end
                V_RD: state_reg <= V_TRG;
                V_TRG: begin
                    env1_reg  <= env1;
                    atk1_reg  <= atk_w | fire;
                    trig1_reg <= trig_n;
                    rate_reg  <= (atk_w | fire) ? rates.attack : rates.decay;
                    gm_reg    <= GM_W'(((SB + RATE_W)'(mag) * (SB + RATE_W)'(rates.gain)) >> 16);
                    neg_reg   <= audio_in[SB-1];
                    state_reg <= V_MUL;
                end
                V_MUL: begin
                    pr_reg    <= ENV_W'((49'(rate_reg) * 49'(env1_reg)) >> ENV_W);
                    state_reg <= V_UPD;
                end
                V_UPD: begin
                    xo_reg    <= xo;
                    state_reg <= V_AMP;
                end
                V_AMP: begin
                    am_reg    <= GM_W'(((GM_W + ENV_W)'(gm_reg) * (GM_W + ENV_W)'(xo_reg))
                                       >> ENV_W);
                    state_reg <= V_ACC;
                end
                V_ACC: begin
                    if (!connected[vidx_reg])
                        sum_reg <= sum_reg + snd;
                    if (vidx_reg == 2'd0)
                        snda_reg <= sat_sb(snd);
                    if (vidx_reg == 2'd2) begin
                        sndc_reg  <= sat_sb(snd);
                        state_reg <= V_FIN;
                    end else begin
                        vidx_reg  <= vidx_reg + 2'd1;
                        state_reg <= V_RD;
                    end
                end
                V_FIN: begin
                    sums_reg  <= sat_sb(sum_reg);
                    done_reg  <= 1'b1;
                    state_reg <= V_IDLE;
                end
                default: state_reg <= V_IDLE;
            endcase
        end
    end

    assign snd_a   = snda_reg;
    assign snd_sum = sums_reg;
    assign snd_c   = sndc_reg;
    assign done    = done_reg;
endmodule

// ===== src/tadv_checker.sv =====
// Port-level checks for the triple attack/decay VCA, bound to the top level.
// Depends on triple_attack_decay_vca's ports only.
module tadv_vca_props #(
    parameter int MAX_CHANNELS = 16,
    parameter int SAMPLE_BITS  = 16
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [3:0]             m_channel,
    input logic [SAMPLE_BITS-1:0] m_sound_out_a
);
    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sound_out_a) && $stable(m_channel))
        else $error("result changed while stalled");

    // one request at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    // no result may appear right after a request taken while no result is valid
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result too early");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_chan: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> int'(m_channel) < MAX_CHANNELS)
        else $error("channel out of range");
endmodule

bind triple_attack_decay_vca tadv_vca_props #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
) u_tadv_vca_props (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_channel     (m_channel),
    .m_sound_out_a (m_sound_out_a)
);
